FILE: rtl/core/urfed_pkg.sv
// Package for the UART receive frame-end detector.
// Holds the command, status, phase and register codes and the shared item types.
// No dependencies.
package urfed_pkg;

  // Size of the receive ring written by DMA, in bytes.
  localparam int unsigned RingBytes = 256;
  localparam int unsigned PosW      = 9;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned RemW      = 16;
  localparam int unsigned TickW     = 16;
  localparam int unsigned TallyW    = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [PosW-1:0]  RingPos          = PosW'(RingBytes);
  localparam logic [TickW-1:0] StallTimeoutRst  = 16'd4608;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_ERROR    = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_DATA = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_IDLE = 2'd1,
    PH_RCV  = 2'd2,
    PH_ERR  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_IDLE    = 3'd1,
    ST_ACK     = 3'd2,
    ST_DATA    = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXPECT_MODE   = 2'd0,
    REG_EXPECTED_LEN  = 2'd1,
    REG_STALL_TIMEOUT = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  typedef struct packed {
    mode_e            expect_mode;
    logic [PosW-1:0]  expected_length;
    logic [TickW-1:0] stall_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_e           frame_status;
    logic [PosW-1:0]   frame_length;
    logic [IdxW-1:0]   last_index;
    logic              timed_out;
    phase_e            rx_state;
    logic              done_pending;
    logic [TallyW-1:0] error_events;
    logic [TallyW-1:0] complete_events;
  } res_t;

endpackage

FILE: rtl/core/uart_rx_frame_end_detector_core.sv
// UART receive frame-end detector, top level: configuration registers,
// detector state and a two-entry result buffer. Depends on urfed_pkg,
// urfed_detect and urfed_out_buf.
//
// Each item (timer tick, DMA complete, DMA error or restart) yields exactly one
// result, stored in the result buffer; while in_stall_o is low a new item may
// enter every cycle. The detector state updates when the item is taken, and the
// result goes into a two-entry buffer, so in_stall_o rises only when two results
// wait unread. Configuration writes are always ready and are meant to happen while
// no item is in flight; a write to an index past the register list is dropped.
module uart_rx_frame_end_detector_core
  import urfed_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [RemW-1:0]     dma_remaining_i,
  // Result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          frame_status_o,
  output logic [PosW-1:0]     frame_length_o,
  output logic [IdxW-1:0]     last_index_o,
  output logic                timed_out_o,
  output logic [1:0]          rx_state_o,
  output logic                done_pending_o,
  output logic [TallyW-1:0]   error_events_o,
  output logic [TallyW-1:0]   complete_events_o
);

  cfg_t cfg_q, cfg_d;
  logic take;
  logic buf_full;
  res_t res_new;
  res_t res_out;

  // Config registers: always ready, decode the index.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_EXPECT_MODE:   cfg_d.expect_mode         = mode_e'(cfg_data_i[1:0]);
        REG_EXPECTED_LEN:  cfg_d.expected_length     = cfg_data_i[PosW-1:0];
        REG_STALL_TIMEOUT: cfg_d.stall_timeout_ticks = cfg_data_i[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expect_mode         <= MODE_NONE;
      cfg_q.expected_length     <= '0;
      cfg_q.stall_timeout_ticks <= StallTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take an item whenever the result buffer has a free slot.
  assign in_stall_o = buf_full;
  assign take       = in_valid_i && !buf_full;

  urfed_detect u_detect (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .cmd_i           (cmd_e'(cmd_i)),
    .dma_remaining_i (dma_remaining_i),
    .cfg_i           (cfg_q),
    .res_o           (res_new)
  );

  urfed_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .res_i   (res_new),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res_out)
  );

  assign frame_status_o    = res_out.frame_status;
  assign frame_length_o    = res_out.frame_length;
  assign last_index_o      = res_out.last_index;
  assign timed_out_o       = res_out.timed_out;
  assign rx_state_o        = res_out.rx_state;
  assign done_pending_o    = res_out.done_pending;
  assign error_events_o    = res_out.error_events;
  assign complete_events_o = res_out.complete_events;

endmodule

FILE: rtl/core/urfed_detect.sv
// Detector state and per-item update for the UART receive frame-end detector.
// Depends on urfed_pkg.
module urfed_detect
  import urfed_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  cmd_e            cmd_i,
  input  logic [RemW-1:0] dma_remaining_i,
  input  cfg_t            cfg_i,
  output res_t            res_o
);

  phase_e            phase_q, phase_d;
  logic              armed_q, armed_d;
  logic              done_q, done_d;
  logic [PosW-1:0]   prev_pos_q, prev_pos_d;
  logic [TickW-1:0]  stall_q, stall_d;
  logic [TallyW-1:0] err_q, err_d;
  logic [TallyW-1:0] cmp_q, cmp_d;

  logic [PosW-1:0] rem_clamp;
  logic [PosW-1:0] wp;
  logic            moved;
  status_e         status;
  logic [PosW-1:0] len;
  logic            fin;

  // Clamp the remaining count to the ring and turn it into a write position.
  assign rem_clamp = (dma_remaining_i > RemW'(RingBytes)) ? RingPos
                                                           : dma_remaining_i[PosW-1:0];
  assign wp        = RingPos - rem_clamp;
  assign moved     = (wp != prev_pos_q);

  always_comb begin
    phase_d    = phase_q;
    armed_d    = armed_q;
    done_d     = done_q;
    prev_pos_d = prev_pos_q;
    stall_d    = stall_q;
    err_d      = err_q;
    cmp_d      = cmp_q;
    status     = ST_NONE;
    len        = '0;
    fin        = 1'b0;

    case (cmd_i)
      CMD_TICK: begin
        if (armed_q) begin
          if (moved) begin
            prev_pos_d = wp;
            phase_d    = PH_RCV;
          end
          if (cfg_i.expect_mode != MODE_NONE) begin
            if (moved) begin
              stall_d = '0;
            end else if (stall_q < cfg_i.stall_timeout_ticks) begin
              stall_d = stall_q + TickW'(1);
            end
            if (cfg_i.expect_mode == MODE_ACK && wp != '0) begin
              status = ST_ACK;
              len    = PosW'(1);
              fin    = 1'b1;
            end else if (cfg_i.expect_mode == MODE_DATA && cfg_i.expected_length != '0 &&
                         wp >= cfg_i.expected_length) begin
              status = ST_DATA;
              len    = cfg_i.expected_length;
              fin    = 1'b1;
            end else if (stall_d >= cfg_i.stall_timeout_ticks) begin
              status = ST_TIMEOUT;
              len    = wp;
              fin    = 1'b1;
            end
          end else if (!moved && phase_q == PH_RCV && wp != '0) begin
            status = ST_IDLE;
            len    = wp;
            fin    = 1'b1;
          end
        end
      end
      CMD_COMPLETE: begin
        cmp_d  = cmp_q + TallyW'(1);
        status = ST_FULL;
        len    = RingPos;
        fin    = 1'b1;
      end
      CMD_ERROR: begin
        err_d = err_q + TallyW'(1);
      end
      CMD_RESTART: begin
        phase_d    = PH_INIT;
        armed_d    = 1'b1;
        done_d     = 1'b0;
        prev_pos_d = '0;
        stall_d    = '0;
      end
      default: begin
      end
    endcase

    // Close the frame: stop the timer and drop back to idle.
    if (fin) begin
      done_d  = 1'b1;
      armed_d = 1'b0;
      phase_d = PH_IDLE;
    end

    res_o.frame_status    = status;
    res_o.frame_length    = len;
    res_o.last_index      = (len == '0) ? '0 : IdxW'(len - PosW'(1));
    res_o.timed_out       = (status == ST_TIMEOUT);
    res_o.rx_state        = phase_d;
    res_o.done_pending    = done_d;
    res_o.error_events    = err_d;
    res_o.complete_events = cmp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_INIT;
      armed_q    <= 1'b1;
      done_q     <= 1'b0;
      prev_pos_q <= '0;
      stall_q    <= '0;
      err_q      <= '0;
      cmp_q      <= '0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      armed_q    <= armed_d;
      done_q     <= done_d;
      prev_pos_q <= prev_pos_d;
      stall_q    <= stall_d;
      err_q      <= err_d;
      cmp_q      <= cmp_d;
    end
  end

endmodule

FILE: rtl/core/urfed_out_buf.sv
// Two-entry result buffer for the UART receive frame-end detector.
// Lets a new item enter while a finished result waits downstream. Depends on urfed_pkg.
module urfed_out_buf
  import urfed_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output res_t res_o
);

  res_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign res_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
